FILE: design/tcce_pkg.sv
package tcce_pkg;

  // Item kinds
  localparam logic [2:0] KIND_STREAM = 3'd0;
  localparam logic [2:0] KIND_PUT    = 3'd1;
  localparam logic [2:0] KIND_SETCUR = 3'd2;
  localparam logic [2:0] KIND_CLEAR  = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  // Control characters
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] DEFAULT_COLOUR = 8'h07;

  // Register indexes
  localparam logic [0:0] REG_TEXT_COLOUR = 1'd0;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // capture the item and decode it
    logic cell_wr;     // write cell at wr address
    logic sweep_init;  // start a sweep
    logic sweep_step;  // advance sweep pointer
    logic scroll_rd;   // read source cell for a scroll copy
    logic finish;      // present the result
  } tcce_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_fill;
    logic need_scroll;
    logic need_clear;
    logic sweep_last;
  } tcce_stat_t;

endpackage

FILE: design/tcce_ctrl.sv
module tcce_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  tcce_pkg::tcce_stat_t stat_i,
  output tcce_pkg::tcce_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_SCRD   = 3'd3;
  localparam logic [2:0] S_SCWR   = 3'd4;
  localparam logic [2:0] S_CLR    = 3'd5;
  localparam logic [2:0] S_CHK    = 3'd6;

  logic [2:0] state_q, state_d;

  // Sequence each item: decode, then fill, scroll copy and clear sweeps
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.sweep_init = 1'b1;
        if (stat_i.need_clear) state_d = S_CLR;
        else if (stat_i.need_fill) state_d = S_FILL;
        else state_d = S_CHK;
      end
      S_FILL: begin
        cmd_o.cell_wr    = 1'b1;
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_last) state_d = S_CHK;
      end
      S_CHK: begin
        if (stat_i.need_scroll) begin
          cmd_o.sweep_init = 1'b1;
          state_d          = S_SCRD;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SCRD: begin
        cmd_o.scroll_rd = 1'b1;
        state_d         = S_SCWR;
      end
      S_SCWR: begin
        cmd_o.cell_wr    = 1'b1;
        cmd_o.sweep_step = 1'b1;
        state_d          = stat_i.sweep_last ? S_CLR : S_SCRD;
      end
      S_CLR: begin
        cmd_o.cell_wr    = 1'b1;
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_last) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: design/tcce_dp.sv
module tcce_dp #(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 25,
  parameter int TAB_WIDTH   = 8,
  parameter int MARGIN_ZONE = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tcce_pkg::tcce_cmd_t  cmd_i,
  output tcce_pkg::tcce_stat_t stat_o,
  input  logic [2:0]           kind_i,
  input  logic [7:0]           char_code_i,
  input  logic [6:0]           col_i,
  input  logic [4:0]           row_i,
  input  logic [7:0]           colour_i,
  output logic                 status_o,
  output logic [7:0]           read_char_o,
  output logic [6:0]           cursor_col_o,
  output logic [4:0]           cursor_row_o,
  output logic [10:0]          cursor_index_o,
  output logic                 done_o
);

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int AW        = $clog2(CELLS);
  localparam int CW        = $clog2(COLUMNS + TAB_WIDTH + 1);
  localparam int RW        = $clog2(ROWS + 1);
  localparam int TAB_STOPS = COLUMNS / TAB_WIDTH + 1;
  localparam logic [CW-1:0] COLS_C   = CW'(COLUMNS);
  localparam logic [CW-1:0] MARGIN_C = CW'(COLUMNS - MARGIN_ZONE);
  localparam logic [RW-1:0] ROWS_C   = RW'(ROWS);
  localparam logic [RW-1:0] LASTR_C  = RW'(ROWS - 1);
  localparam logic [AW-1:0] SCR_END  = AW'(COLUMNS * (ROWS - 1) - 1);
  localparam logic [AW-1:0] CLR2_ST  = AW'(COLUMNS * (ROWS - 2));
  localparam logic [AW-1:0] LAST_C   = AW'(CELLS - 1);

  // Grids: char and attribute, cleared by a sweep after reset
  logic [7:0] char_mem [CELLS];
  logic [7:0] attr_mem [CELLS];

  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic          status_q, status_d;
  logic [7:0]    rchar_q, rchar_d;
  logic          fill_q, fill_d, scroll_q, clear_q, clear_d;
  logic [2:0]    kind_q;
  logic [AW-1:0] ptr_q, end_q;
  logic [7:0]    src_ch_q, src_at_q;
  logic          phase_q;      // 0 fill/copy, 1 clear
  logic          done_q;

  // Memory read data and row base helpers
  logic [7:0]    mem_ch_q;
  logic [AW-1:0] row_base, in_addr, cur_addr;
  logic          in_range;

  assign row_base = AW'(cur_row_q * COLUMNS);
  assign cur_addr = row_base + AW'(cur_col_q);
  assign in_addr  = AW'(row_i * COLUMNS) + AW'(col_i);
  assign in_range = ({1'b0, col_i} < 8'(COLUMNS)) && ({1'b0, row_i} < 6'(ROWS));

  // Next tab stop: smallest multiple of TAB_WIDTH above the cursor column
  logic [CW-1:0] tab_stop;

  always_comb begin
    tab_stop = COLS_C;
    for (int m = TAB_STOPS; m >= 1; m--) begin
      if (m * TAB_WIDTH > int'(cur_col_q)) tab_stop = CW'(m * TAB_WIDTH);
    end
  end

  // Decode the item in one step; memory single-cell writes happen here too
  logic          we1;
  logic [AW-1:0] wa1;
  logic [7:0]    wc1, wat1;
  logic          keep_attr1;
  logic          wrap;

  always_comb begin
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    status_d   = 1'b0;
    rchar_d    = 8'd0;
    we1        = 1'b0;
    wa1        = cur_addr;
    wc1        = char_code_i;
    wat1       = colour_i;
    keep_attr1 = 1'b0;
    fill_d     = 1'b0;
    clear_d    = 1'b0;
    wrap       = 1'b0;
    case (kind_i)
      tcce_pkg::KIND_STREAM: begin
        if (char_code_i == tcce_pkg::CH_BS) begin
          if (cur_col_q == '0 && cur_row_q != '0) begin
            cur_col_d = COLS_C - 1'b1;
            cur_row_d = cur_row_q - 1'b1;
          end else if (cur_col_q != '0) begin
            cur_col_d = cur_col_q - 1'b1;
          end
          if (cur_row_d < ROWS_C && cur_col_d < COLS_C) begin
            we1        = 1'b1;
            wa1        = AW'(cur_row_d * COLUMNS) + AW'(cur_col_d);
            wc1        = 8'd0;
            keep_attr1 = 1'b1;
          end
        end else if (char_code_i == tcce_pkg::CH_NL) begin
          cur_row_d = cur_row_q + 1'b1;
          cur_col_d = '0;
        end else if (char_code_i == tcce_pkg::CH_TAB) begin
          cur_col_d = tab_stop;
        end else begin
          if (cur_col_q < COLS_C && cur_row_q < ROWS_C) we1 = 1'b1;
          cur_col_d = cur_col_q + 1'b1;
        end
        // line check: wrap or margin fill
        wrap = (cur_col_d >= COLS_C) ||
               (char_code_i == tcce_pkg::CH_SPACE && cur_col_d >= MARGIN_C);
        if (wrap && cur_col_d < COLS_C && cur_row_d < ROWS_C) fill_d = 1'b1;
      end
      tcce_pkg::KIND_PUT: begin
        if (in_range) begin
          we1 = 1'b1;
          wa1 = in_addr;
        end else status_d = 1'b1;
      end
      tcce_pkg::KIND_SETCUR: begin
        if (in_range) begin
          cur_col_d = CW'(col_i);
          cur_row_d = RW'(row_i);
        end else status_d = 1'b1;
      end
      tcce_pkg::KIND_CLEAR: begin
        cur_col_d = '0;
        cur_row_d = '0;
        clear_d   = 1'b1;
      end
      tcce_pkg::KIND_READ: begin
        if (!in_range) status_d = 1'b1;
      end
      default: status_d = 1'b1;
    endcase
  end

  // Cursor only moves at load and scroll end; wraps at load for stream items
  logic [AW-1:0] fill_start;
  assign fill_start = AW'(cur_row_d * COLUMNS) + AW'(cur_col_d);

  // Hold item state and sweep pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
      status_q  <= 1'b0;
      rchar_q   <= 8'd0;
      fill_q    <= 1'b0;
      scroll_q  <= 1'b0;
      clear_q   <= 1'b0;
      kind_q    <= '0;
      phase_q   <= 1'b0;
      done_q    <= 1'b0;
      ptr_q     <= '0;
      end_q     <= '0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.load) begin
        status_q  <= status_d;
        rchar_q   <= 8'd0;
        fill_q    <= fill_d;
        clear_q   <= clear_d;
        kind_q    <= kind_i;
        phase_q   <= 1'b0;
        ptr_q     <= fill_start;
        end_q     <= row_base + AW'(COLUMNS - 1);
        if (kind_i == tcce_pkg::KIND_STREAM && wrap) begin
          cur_col_q <= '0;
          cur_row_q <= cur_row_d + 1'b1;
          end_q     <= AW'(cur_row_d * COLUMNS) + AW'(COLUMNS - 1);
        end else begin
          cur_col_q <= cur_col_d;
          cur_row_q <= cur_row_d;
        end
        scroll_q <= 1'b0;
      end else if (cmd_i.sweep_init) begin
        if (clear_q) begin
          ptr_q   <= '0;
          end_q   <= LAST_C;
          phase_q <= 1'b1;
        end else if (!fill_q || phase_q == 1'b0 && scroll_q) begin
          ptr_q <= '0;
          end_q <= SCR_END;
        end
        if (!clear_q && !fill_q) scroll_q <= 1'b1;
        fill_q <= 1'b0;
        if (kind_q == tcce_pkg::KIND_READ && !status_q) rchar_q <= mem_ch_q;
      end else if (cmd_i.sweep_step) begin
        if (ptr_q == end_q) begin
          if (scroll_q && phase_q == 1'b0) begin
            ptr_q   <= CLR2_ST;
            end_q   <= LAST_C;
            phase_q <= 1'b1;
            if (cur_row_q != '0) cur_row_q <= cur_row_q - 1'b1;
          end
          scroll_q <= 1'b0;
        end else begin
          ptr_q <= ptr_q + 1'b1;
        end
      end
    end
  end

  // Memory port: single write per cycle, registered read
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_ch, wr_at;
  logic          wr_en, wr_keep_attr;
  logic [AW-1:0] rd_addr;

  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = ptr_q;
    wr_ch        = 8'd0;
    wr_at        = colour_i;
    wr_keep_attr = 1'b0;
    if (cmd_i.load && kind_i != tcce_pkg::KIND_READ) begin
      wr_en        = we1;
      wr_addr      = wa1;
      wr_ch        = wc1;
      wr_at        = wat1;
      wr_keep_attr = keep_attr1;
    end else if (cmd_i.cell_wr) begin
      wr_en = 1'b1;
      if (phase_q) begin
        wr_ch = 8'd0;
      end else if (scroll_q) begin
        wr_ch = src_ch_q;
        wr_at = src_at_q;
      end else begin
        wr_ch = tcce_pkg::CH_SPACE;
      end
    end
    rd_addr = cmd_i.scroll_rd ? ptr_q + AW'(COLUMNS) : in_addr;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      char_mem[wr_addr] <= wr_ch;
      if (!wr_keep_attr) attr_mem[wr_addr] <= wr_at;
    end
    mem_ch_q <= char_mem[rd_addr];
    src_ch_q <= char_mem[rd_addr];
    src_at_q <= attr_mem[rd_addr];
  end

  assign stat_o.need_fill   = fill_q;
  assign stat_o.need_clear  = clear_q;
  assign stat_o.need_scroll = (kind_q == tcce_pkg::KIND_STREAM) && (cur_row_q >= LASTR_C);
  assign stat_o.sweep_last  = (ptr_q == end_q);

  assign status_o       = status_q;
  assign read_char_o    = rchar_q;
  assign cursor_col_o   = 7'(cur_col_q);
  assign cursor_row_o   = 5'(cur_row_q);
  assign cursor_index_o = 11'(cur_row_q * COLUMNS + cur_col_q);
  assign done_o         = done_q;

endmodule

FILE: design/text_console_char_engine_top.sv
// Text console engine. Issue an item with start while busy is low; one
// result follows, shown for exactly one cycle with done_o high, and the
// receiver cannot stall it. A stream item may add a margin fill sweep, a
// scroll copy that reads and then writes each cell, and a clear of the last
// two rows; a clear item sweeps the whole grid. All sweeps go through the
// single grid memory port, and busy stays high while an item is processed.
// After reset the grid is cleared by an internal sweep, and busy stays high
// until that clearing pass is over.
module text_console_char_engine_top #(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 25,
  parameter int TAB_WIDTH   = 8,
  parameter int MARGIN_ZONE = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  char_code_i,
  input  logic [6:0]  col_i,
  input  logic [4:0]  row_i,
  output logic        done_o,
  output logic        status_o,
  output logic [7:0]  read_char_o,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_row_o,
  output logic [10:0] cursor_index_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] ADDR_TEXT_COLOUR = 2'(4 * tcce_pkg::REG_TEXT_COLOUR);

  tcce_pkg::tcce_cmd_t  cmd;
  tcce_pkg::tcce_stat_t stat;
  logic [7:0]  colour_q;
  logic        init_q, init_d1_q, ctrl_busy, done_int;
  logic [2:0]  kind_eff;
  logic [7:0]  init_colour;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_q <= tcce_pkg::DEFAULT_COLOUR;
    end else if (psel && penable && pwrite && paddr == ADDR_TEXT_COLOUR) begin
      colour_q <= pwdata[7:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TEXT_COLOUR) ? {24'd0, colour_q} : 32'd0;

  // Clearing pass after reset: issue one internal clear item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b1;
    end else if (!ctrl_busy) begin
      init_q <= 1'b0;
    end
  end

  // Keep the default colour for the whole clearing pass
  assign init_colour = init_d1_q ? tcce_pkg::DEFAULT_COLOUR : colour_q;
  assign kind_eff    = init_q ? tcce_pkg::KIND_CLEAR : kind_i;

  tcce_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (init_q | (start & ~busy)),
    .busy_o  (ctrl_busy),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  tcce_dp #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .TAB_WIDTH   (TAB_WIDTH),
    .MARGIN_ZONE (MARGIN_ZONE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .kind_i         (kind_eff),
    .char_code_i    (char_code_i),
    .col_i          (col_i),
    .row_i          (row_i),
    .colour_i       (init_colour),
    .status_o       (status_o),
    .read_char_o    (read_char_o),
    .cursor_col_o   (cursor_col_o),
    .cursor_row_o   (cursor_row_o),
    .cursor_index_o (cursor_index_o),
    .done_o         (done_int)
  );

  // Drop the result of the internal clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_d1_q <= 1'b1;
    end else if (done_int) begin
      init_d1_q <= 1'b0;
    end
  end

  assign done_o = done_int & ~init_d1_q;
  assign busy   = ctrl_busy | init_q | (done_int & init_d1_q);

endmodule

FILE: sim/tb.sv
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int TAB_WIDTH   = 8;
  localparam int MARGIN_ZONE = 7;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam logic [2:0] KIND_BAD_LO = 3'd5;
  localparam logic [2:0] KIND_BAD_HI = 3'd7;

  typedef struct packed {
    logic        status;
    logic [7:0]  read_char;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_index;
  } console_reply_t;

  // Console shadow: grids, cursor and colour, plus the queue of pending replies
  class console_scoreboard;
    logic [7:0] chars [CELLS];
    logic [7:0] attrs [CELLS];
    logic [7:0] colour;
    int unsigned col_q;
    int unsigned row_q;
    console_reply_t pending [$];
    int unsigned errors;

    function new();
      for (int i = 0; i < CELLS; i++) begin
        chars[i] = 8'h00;
        attrs[i] = tcce_pkg::DEFAULT_COLOUR;
      end
      colour = tcce_pkg::DEFAULT_COLOUR;
      col_q  = 0;
      row_q  = 0;
      errors = 0;
    endfunction

    function void wipe_rows(int from, int upto);
      for (int i = from * COLUMNS; i < upto * COLUMNS; i++) begin
        chars[i] = 8'h00;
        attrs[i] = colour;
      end
    endfunction

    function void put(int c, int r, logic [7:0] ch);
      if (c < COLUMNS && r < ROWS) begin
        chars[r * COLUMNS + c] = ch;
        attrs[r * COLUMNS + c] = colour;
      end
    endfunction

    // Wrap, margin fill and scroll after a streamed character
    function void end_of_char(logic [7:0] ch);
      if (col_q >= COLUMNS ||
          (ch == tcce_pkg::CH_SPACE && col_q >= COLUMNS - MARGIN_ZONE)) begin
        for (int c = int'(col_q); c < COLUMNS; c++) put(c, int'(row_q), tcce_pkg::CH_SPACE);
        col_q = 0;
        row_q++;
      end
      if (row_q >= ROWS - 1) begin
        for (int i = 0; i < COLUMNS * (ROWS - 1); i++) begin
          chars[i] = chars[i + COLUMNS];
          attrs[i] = attrs[i + COLUMNS];
        end
        wipe_rows(ROWS - 2, ROWS);
        row_q = (row_q > 0) ? row_q - 1 : 0;
      end
    endfunction

    function void stream(logic [7:0] ch);
      if (ch == tcce_pkg::CH_BS) begin
        if (col_q == 0 && row_q != 0) begin
          col_q = COLUMNS;
          row_q--;
        end
        if (col_q != 0) col_q--;
        chars[row_q * COLUMNS + col_q] = 8'h00;
      end else if (ch == tcce_pkg::CH_NL) begin
        row_q++;
        col_q = 0;
      end else if (ch == tcce_pkg::CH_TAB) begin
        col_q = (col_q / TAB_WIDTH + 1) * TAB_WIDTH;
      end else begin
        put(int'(col_q), int'(row_q), ch);
        col_q++;
      end
      end_of_char(ch);
    endfunction

    // Note an accepted item and queue its reply
    function void note_item(logic [2:0] kind, logic [7:0] ch, logic [6:0] c, logic [4:0] r);
      console_reply_t rep;
      bit fits;
      fits = (c < COLUMNS) && (r < ROWS);
      rep = '0;
      case (kind)
        tcce_pkg::KIND_STREAM: stream(ch);
        tcce_pkg::KIND_PUT: begin
          if (fits) put(c, r, ch);
          else rep.status = 1'b1;
        end
        tcce_pkg::KIND_SETCUR: begin
          if (fits) begin
            col_q = c;
            row_q = r;
          end else begin
            rep.status = 1'b1;
          end
        end
        tcce_pkg::KIND_CLEAR: begin
          wipe_rows(0, ROWS);
          col_q = 0;
          row_q = 0;
        end
        tcce_pkg::KIND_READ: begin
          if (fits) rep.read_char = chars[r * COLUMNS + c];
          else rep.status = 1'b1;
        end
        default: rep.status = 1'b1;
      endcase
      rep.cursor_col   = col_q[6:0];
      rep.cursor_row   = row_q[4:0];
      rep.cursor_index = 11'(row_q * COLUMNS + col_q);
      pending.push_back(rep);
    endfunction

    // Compare a reply against the oldest pending one
    function void check_reply(console_reply_t got);
      console_reply_t exp;
      if (pending.size() == 0) begin
        $error("unexpected reply %p", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $error("status exp %0d got %0d", exp.status, got.status); errors++;
      end
      if (got.read_char !== exp.read_char) begin
        $error("read_char exp %0h got %0h", exp.read_char, got.read_char); errors++;
      end
      if (got.cursor_col !== exp.cursor_col) begin
        $error("cursor_col exp %0d got %0d", exp.cursor_col, got.cursor_col); errors++;
      end
      if (got.cursor_row !== exp.cursor_row) begin
        $error("cursor_row exp %0d got %0d", exp.cursor_row, got.cursor_row); errors++;
      end
      if (got.cursor_index !== exp.cursor_index) begin
        $error("cursor_index exp %0d got %0d", exp.cursor_index, got.cursor_index);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  kind_i = '0;
  logic [7:0]  char_code_i = '0;
  logic [6:0]  col_i = '0;
  logic [4:0]  row_i = '0;
  logic        done_o;
  logic        status_o;
  logic [7:0]  read_char_o;
  logic [6:0]  cursor_col_o;
  logic [4:0]  cursor_row_o;
  logic [10:0] cursor_index_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  console_scoreboard board;
  int unsigned idle_pct;

  text_console_char_engine_top #(
    .COLUMNS(COLUMNS), .ROWS(ROWS), .TAB_WIDTH(TAB_WIDTH), .MARGIN_ZONE(MARGIN_ZONE)
  ) dut (.*);

  always #10 clk_i = ~clk_i;

  // Check every reply on the edge that ends its strobe cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      board.check_reply('{status_o, read_char_o, cursor_col_o, cursor_row_o,
                          cursor_index_o});
    end
  end

  // Issue one item, with a random gap in front of it; drop start after acceptance
  task automatic send_item(logic [2:0] kind, logic [7:0] ch, logic [6:0] c, logic [4:0] r);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    start       <= 1'b1;
    kind_i      <= kind;
    char_code_i <= ch;
    col_i       <= c;
    row_i       <= r;
    do @(posedge clk_i); while (busy);
    board.note_item(kind, ch, c, r);
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold until the block is idle and every reply is in, then let stragglers settle
  task automatic drain();
    while (board.pending.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_colour(logic [7:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'(4 * tcce_pkg::REG_TEXT_COLOUR);
    pwdata  <= {$urandom} & 32'hFFFF_FF00 | 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.colour = value;
  endtask

  // Mostly printable text with control characters and wide bytes mixed in
  function automatic logic [7:0] pick_char();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 8) return tcce_pkg::CH_NL;
    if (p < 14) return tcce_pkg::CH_TAB;
    if (p < 20) return tcce_pkg::CH_BS;
    if (p < 40) return tcce_pkg::CH_SPACE;
    if (p < 85) return 8'($urandom_range(8'h21, 8'h7E));
    return 8'($urandom_range(255));
  endfunction

  task automatic random_item();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) send_item(tcce_pkg::KIND_STREAM, pick_char(), 7'($urandom), 5'($urandom));
    else if (p < 78)
      send_item(tcce_pkg::KIND_PUT, 8'($urandom), 7'($urandom_range(0, 90)),
                5'($urandom_range(0, 27)));
    else if (p < 84)
      send_item(tcce_pkg::KIND_SETCUR, 8'($urandom), 7'($urandom_range(0, 127)),
                5'($urandom_range(0, 31)));
    else if (p < 96)
      send_item(tcce_pkg::KIND_READ, 8'($urandom), 7'($urandom_range(0, 90)),
                5'($urandom_range(0, 27)));
    else if (p < 98) send_item(3'($urandom_range(KIND_BAD_LO, KIND_BAD_HI)), 8'($urandom),
                               7'($urandom), 5'($urandom));
    else send_item(tcce_pkg::KIND_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
  endtask

  initial begin
    board = new();
    idle_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every kind, control characters and edge rules
    write_colour(8'hFF);
    send_item(tcce_pkg::KIND_STREAM, tcce_pkg::CH_BS, 7'd0, 5'd0);
    send_item(tcce_pkg::KIND_STREAM, 8'hFF, 7'h7F, 5'h1F);
    send_item(tcce_pkg::KIND_STREAM, tcce_pkg::CH_TAB, 7'd0, 5'd0);
    send_item(tcce_pkg::KIND_PUT, 8'h41, 7'd79, 5'd24);
    send_item(tcce_pkg::KIND_READ, 8'h00, 7'd79, 5'd24);
    send_item(tcce_pkg::KIND_PUT, 8'h42, 7'd80, 5'd0);
    send_item(tcce_pkg::KIND_PUT, 8'h42, 7'd0, 5'd25);
    send_item(tcce_pkg::KIND_READ, 8'h00, 7'd127, 5'd31);
    send_item(tcce_pkg::KIND_SETCUR, 8'h00, 7'd127, 5'd31);
    send_item(tcce_pkg::KIND_SETCUR, 8'h00, 7'd74, 5'd3);
    send_item(tcce_pkg::KIND_STREAM, tcce_pkg::CH_SPACE, 7'd0, 5'd0);
    send_item(tcce_pkg::KIND_STREAM, tcce_pkg::CH_BS, 7'd0, 5'd0);
    send_item(tcce_pkg::KIND_SETCUR, 8'h00, 7'd79, 5'd22);
    send_item(tcce_pkg::KIND_STREAM, 8'h5A, 7'd0, 5'd0);
    send_item(tcce_pkg::KIND_READ, 8'h00, 7'd79, 5'd21);
    send_item(tcce_pkg::KIND_SETCUR, 8'h00, 7'd0, 5'd24);
    send_item(tcce_pkg::KIND_STREAM, tcce_pkg::CH_NL, 7'd0, 5'd0);
    send_item(tcce_pkg::KIND_SETCUR, 8'h00, 7'd78, 5'd5);
    send_item(tcce_pkg::KIND_STREAM, tcce_pkg::CH_TAB, 7'd0, 5'd0);
    send_item(tcce_pkg::KIND_READ, 8'h00, 7'd0, 5'd0);
    send_item(KIND_BAD_LO, 8'h00, 7'd0, 5'd0);
    send_item(KIND_BAD_HI, 8'hFF, 7'h7F, 5'h1F);
    send_item(tcce_pkg::KIND_CLEAR, 8'h00, 7'd0, 5'd0);
    write_colour(8'h00);
    send_item(tcce_pkg::KIND_PUT, 8'h00, 7'd0, 5'd0);

    // Random phases: sender idles rarely, often, then never
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 18 : (ph == 1) ? 86 : 0;
      write_colour(ph == 2 ? tcce_pkg::DEFAULT_COLOUR : 8'($urandom));
      for (int n = 0; n < 300; n++) begin
        if (n == 150) drain();
        random_item();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: generous bound over scroll-heavy worst case
  initial begin
    #2s;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
